FILE: src/mwsm_pkg.sv
// ----------------------------------------------------------------------------
// mwsm_pkg
// Shared types and constants for the mecanum wheel speed mixer.
// ----------------------------------------------------------------------------
`default_nettype none
package mwsm_pkg;

   localparam int VEL_W    = 15;
   localparam int MIX_W    = 17;
   localparam int MAG_W    = 16;
   localparam int LIM_W    = 15;
   localparam int WHEEL_W  = 16;
   localparam int WHEELS   = 4;
   localparam int QUO_W    = LIM_W;
   localparam int PROD_W   = MAG_W + LIM_W;
   localparam logic [LIM_W-1:0] LIM_RESET = 15'd8000;

   localparam int WH_FL = 0;
   localparam int WH_FR = 1;
   localparam int WH_BL = 2;
   localparam int WH_BR = 3;

   typedef struct packed {
      logic                                valid;
      logic                                scaled;
      logic [MAG_W-1:0]                    peak;
      logic [WHEELS-1:0]                   neg;
      logic [WHEELS-1:0][WHEEL_W-1:0]      raw;
      logic [WHEELS-1:0][PROD_W-1:0]       rem;
      logic [WHEELS-1:0][QUO_W-1:0]        quo;
   } mwsm_item_type;

endpackage
`default_nettype wire

FILE: src/mwsm_front.sv
// ----------------------------------------------------------------------------
// mwsm_front
// Wheel mixing, peak search and scaling products, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module mwsm_front
   import mwsm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     adv,
   input  wire logic                     in_valid,
   input  wire logic signed [VEL_W-1:0]  vel_x,
   input  wire logic signed [VEL_W-1:0]  vel_y,
   input  wire logic signed [VEL_W-1:0]  vel_w,
   input  wire logic [LIM_W-1:0]         lim,
   output mwsm_item_type                 item_ff
);

   logic                                  mix_valid_ff;
   logic signed [WHEELS-1:0][MIX_W-1:0]   mix_ff;
   logic signed [MIX_W-1:0]               x_e, y_e, w_e;
   logic [WHEELS-1:0][MIX_W-1:0]          mix_in;
   logic [WHEELS-1:0][MAG_W-1:0]          mag;
   logic [MAG_W-1:0]                      pk_a, pk_b, peak;
   mwsm_item_type                         item_in;

   always_comb begin
      x_e = MIX_W'(vel_x);
      y_e = MIX_W'(vel_y);
      w_e = MIX_W'(vel_w);
      mix_in[WH_FL] = x_e + y_e - w_e;
      mix_in[WH_FR] = y_e - x_e - w_e;
      mix_in[WH_BL] = x_e - y_e - w_e;
      mix_in[WH_BR] = MIX_W'(0) - x_e - y_e - w_e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_valid_ff <= 1'b0;
      end else if (adv) begin
         mix_valid_ff <= in_valid;
         mix_ff       <= mix_in;
      end
   end

   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         mag[i] = mix_ff[i][MIX_W-1] ? MAG_W'(MIX_W'(0) - mix_ff[i]) : mix_ff[i][MAG_W-1:0];
      end
      pk_a = (mag[0] > mag[1]) ? mag[0] : mag[1];
      pk_b = (mag[2] > mag[3]) ? mag[2] : mag[3];
      peak = (pk_a > pk_b) ? pk_a : pk_b;
      item_in.valid  = mix_valid_ff;
      item_in.peak   = peak;
      item_in.scaled = peak > MAG_W'(lim);
      for (int i = 0; i < WHEELS; i++) begin
         item_in.neg[i] = mix_ff[i][MIX_W-1];
         item_in.raw[i] = mix_ff[i][WHEEL_W-1:0];
         item_in.rem[i] = PROD_W'(mag[i]) * PROD_W'(lim);
         item_in.quo[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (adv) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/mwsm_cell.sv
// ----------------------------------------------------------------------------
// mwsm_cell
// One restoring division step: settles one quotient bit for all four wheels.
// ----------------------------------------------------------------------------
`default_nettype none
module mwsm_cell
   import mwsm_pkg::*;
#(
   parameter int BIT = 0
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire mwsm_item_type item_in,
   output mwsm_item_type      item_ff
);

   localparam int SUB_W = PROD_W + 1;

   logic [WHEELS-1:0][SUB_W-1:0] diff;
   logic [SUB_W-1:0]             div_sh;
   mwsm_item_type                item_nx;

   always_comb begin
      item_nx = item_in;
      div_sh  = SUB_W'(item_in.peak) << BIT;
      for (int i = 0; i < WHEELS; i++) begin
         diff[i] = {1'b0, item_in.rem[i]} - div_sh;
         if (!diff[i][SUB_W-1]) begin
            item_nx.rem[i]      = diff[i][PROD_W-1:0];
            item_nx.quo[i][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (adv) begin
         item_ff <= item_nx;
      end
   end

endmodule
`default_nettype wire

FILE: src/mecanum_wheel_speed_mixer_core.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer_core
// Mecanum inverse kinematics with proportional desaturation to a set limit.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: vel_x, vel_y, vel_w
// rsp      out  rsp_tvalid/rsp_tready  tdata: four wheels; tuser: was_scaled
// csr      in   csr_valid/csr_ready    data: wheel speed limit
//
// One transaction per cycle while rsp is not stalled; 18 register stages (2 mix
// stages, 15 divider cells one quotient bit each, 1 output register).
// Synchronous reset clears valid flags; limit resets to 8000.
// A stall at rsp freezes the whole chain; csr is always ready.
// ----------------------------------------------------------------------------
`default_nettype none
module mecanum_wheel_speed_mixer_core
   import mwsm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // vel_x, vel_y, vel_w, zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // front left, front right, back left, back right
   output logic             rsp_tuser,   // was_scaled
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data     // wheel speed limit, zero pad
);

   logic                                 adv;
   logic [LIM_W-1:0]                     lim_ff;
   mwsm_item_type                        chain [QUO_W+1];
   logic [WHEELS-1:0][WHEEL_W-1:0]       out_in;
   logic [WHEELS-1:0][WHEEL_W-1:0]       out_ff;
   logic                                 scl_ff;
   logic                                 vld_ff;
   logic [WHEEL_W-1:0]                   fl_mag;
   mwsm_item_type                        last;

   assign adv        = !vld_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= LIM_RESET;
      end else if (csr_valid) begin
         lim_ff <= csr_data[LIM_W-1:0];
      end
   end

   mwsm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .vel_x    (req_tdata[VEL_W-1:0]),
      .vel_y    (req_tdata[2*VEL_W-1:VEL_W]),
      .vel_w    (req_tdata[3*VEL_W-1:2*VEL_W]),
      .lim      (lim_ff),
      .item_ff  (chain[QUO_W])
   );

   for (genvar k = QUO_W - 1; k >= 0; k--) begin : g_cell
      mwsm_cell #(.BIT(k)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .item_in (chain[k+1]),
         .item_ff (chain[k])
      );
   end

   assign last = chain[0];

   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         if (last.scaled) begin
            out_in[i] = last.neg[i] ? WHEEL_W'(WHEEL_W'(0) - WHEEL_W'(last.quo[i]))
                                    : WHEEL_W'(last.quo[i]);
         end else begin
            out_in[i] = last.raw[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= last.valid;
         out_ff <= out_in;
         scl_ff <= last.scaled;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = scl_ff;

   assign fl_mag = out_ff[WH_FL][WHEEL_W-1] ? WHEEL_W'(WHEEL_W'(0) - out_ff[WH_FL])
                                            : out_ff[WH_FL];

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow output stall");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_scaled_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser && $stable(lim_ff)) |-> (fl_mag <= WHEEL_W'(lim_ff)))
      else $error("scaled wheel exceeds limit");

endmodule
`default_nettype wire

FILE: dv/mecanum_wheel_speed_mixer_core_test.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer_core_test
// Drives chassis velocity commands through the mixer under random stalls on
// both sides, predicts each wheel set with proportional desaturation and
// compares every rsp transaction, in order, with the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mecanum_wheel_speed_mixer_core_test
   import mwsm_pkg::*;
;

   typedef struct packed {
      logic signed [VEL_W-1:0] vx;
      logic signed [VEL_W-1:0] vy;
      logic signed [VEL_W-1:0] vw;
   } command_type;

   typedef struct packed {
      logic signed [WHEEL_W-1:0] fl;
      logic signed [WHEEL_W-1:0] fr;
      logic signed [WHEEL_W-1:0] bl;
      logic signed [WHEEL_W-1:0] br;
      logic                      scaled;
   } wheels_type;

   localparam int LATENCY = 18;
   localparam longint CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   mecanum_wheel_speed_mixer_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   command_type   pending_cmds[$];
   wheels_type    expected_wheels[$];
   logic [LIM_W-1:0] rpm_limit = LIM_RESET;
   int         mismatches = 0;
   longint     cycles = 0;
   int         send_gap = 0;
   int         recv_gap = 0;
   int         hold_cycles = 0;
   bit         send_pause = 1'b0;

   function automatic wheels_type mix_wheels(command_type c, logic [LIM_W-1:0] lim);
      longint w[4];
      longint peak;
      longint m;
      wheels_type r;
      w[0] = c.vx + c.vy - c.vw;
      w[1] = -(c.vx - c.vy + c.vw);
      w[2] = c.vx - c.vy - c.vw;
      w[3] = -(c.vx + c.vy + c.vw);
      peak = 0;
      foreach (w[i]) begin
         m = w[i] < 0 ? -w[i] : w[i];
         if (m > peak) peak = m;
      end
      r.scaled = peak > longint'(lim);
      if (r.scaled)
         foreach (w[i]) w[i] = (w[i] * longint'(lim)) / peak;
      r.fl = w[0][15:0];
      r.fr = w[1][15:0];
      r.bl = w[2][15:0];
      r.br = w[3][15:0];
      return r;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      command_type c;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_wheels.push_back(mix_wheels(pending_cmds.pop_front(), rpm_limit));
            send_gap <= $urandom_range(0, 6);
         end
         if (req_tvalid && !req_tready) begin
         end else if (send_gap > 0 && !(req_tvalid && req_tready)) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!send_pause && pending_cmds.size() > 0
                      && !(req_tvalid && req_tready && $urandom_range(0, 2) == 0)) begin
            c = pending_cmds[0];
            req_tvalid <= 1'b1;
            req_tdata  <= {3'b000, c.vw, c.vy, c.vx};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      wheels_type got;
      wheels_type exp_w;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32],
                   rsp_tdata[63:48], rsp_tuser};
            if (expected_wheels.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected rsp transaction %h", got);
            end else begin
               exp_w = expected_wheels.pop_front();
               if (got !== exp_w) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display({"mismatch exp fl %0d fr %0d bl %0d br %0d s %0b",
                               " got fl %0d fr %0d bl %0d br %0d s %0b"},
                              exp_w.fl, exp_w.fr, exp_w.bl, exp_w.br, exp_w.scaled,
                              got.fl, got.fr, got.bl, got.br, got.scaled);
               end
            end
            recv_gap <= $urandom_range(0, 6);
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0 && !(rsp_tvalid && rsp_tready)) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(rsp_tvalid && rsp_tready) || $urandom_range(0, 2) != 0;
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("[mecanum_wheel_speed_mixer_core] ERROR");
         $finish;
      end
   end

   function automatic command_type rand_cmd(int span);
      command_type c;
      if (span >= 16383) begin
         c.vx = $urandom; c.vy = $urandom; c.vw = $urandom;
      end else begin
         c.vx = $urandom_range(0, 2 * span) - span;
         c.vy = $urandom_range(0, 2 * span) - span;
         c.vw = $urandom_range(0, 2 * span) - span;
      end
      return c;
   endfunction

   task automatic drain();
      wait (pending_cmds.size() == 0 && !req_tvalid);
      wait (expected_wheels.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_limit(logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rpm_limit = value[LIM_W-1:0];
   endtask

   initial begin
      logic [15:0] limits[6];
      command_type c;
      limits = '{16'd0, 16'd1, 16'h7FFF, 16'hFFFF, 16'd8000, 16'd300};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, balanced and zero mixes under reset limit
      pending_cmds.push_back('{15'sd0, 15'sd0, 15'sd0});
      pending_cmds.push_back('{15'h3FFF, 15'h3FFF, 15'h3FFF});
      pending_cmds.push_back('{15'h4000, 15'h4000, 15'h4000});
      pending_cmds.push_back('{15'h3FFF, 15'h4000, 15'h3FFF});
      pending_cmds.push_back('{15'h4000, 15'h3FFF, 15'h4000});
      pending_cmds.push_back('{15'sd2000, 15'sd2000, 15'sd4000});
      pending_cmds.push_back('{15'sd8000, 15'sd0, 15'sd0});
      pending_cmds.push_back('{15'sd8001, 15'sd0, 15'sd0});
      pending_cmds.push_back('{-15'sd1, -15'sd1, -15'sd1});
      pending_cmds.push_back('{15'sd0, 15'sd0, 15'h4000});
      drain();

      // limit of zero and of one, full range at top limit
      write_limit(16'd0);
      pending_cmds.push_back('{15'sd0, 15'sd0, 15'sd0});
      pending_cmds.push_back('{15'sd1, 15'sd0, 15'sd0});
      pending_cmds.push_back('{15'h4000, 15'h3FFF, 15'sd5});
      drain();
      write_limit(16'd1);
      pending_cmds.push_back('{15'sd1, 15'sd0, 15'sd0});
      pending_cmds.push_back('{15'sd1, 15'sd1, 15'sd0});
      pending_cmds.push_back('{15'sd0, 15'sd0, 15'sd0});
      drain();
      write_limit(16'hFFFF);
      pending_cmds.push_back('{15'h3FFF, 15'h3FFF, 15'h4000});
      pending_cmds.push_back('{15'h4000, 15'h4000, 15'h3FFF});
      drain();

      // random phases over several limits
      foreach (limits[k]) begin
         write_limit(limits[k]);
         for (int n = 0; n < 230; n++) begin
            case ($urandom_range(0, 3))
               0: c = rand_cmd(16383);
               1: c = rand_cmd(3000);
               2: c = rand_cmd(40);
               default: c = rand_cmd(limits[k][14:0] / 3 + 1);
            endcase
            pending_cmds.push_back(c);
         end
         if (k == 2) begin
            wait (pending_cmds.size() < 150);
            hold_cycles = 300;
         end
         if (k == 4) begin
            wait (pending_cmds.size() < 100);
            send_pause = 1'b1;
            wait (!req_tvalid);
            wait (expected_wheels.size() == 0);
            send_pause = 1'b0;
         end
         drain();
      end

      if (mismatches == 0 && expected_wheels.size() == 0)
         $display("[mecanum_wheel_speed_mixer_core] OK");
      else
         $display("[mecanum_wheel_speed_mixer_core] ERROR");
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
src/mwsm_pkg.sv
src/mwsm_front.sv
src/mwsm_cell.sv
src/mecanum_wheel_speed_mixer_core.sv
dv/mecanum_wheel_speed_mixer_core_test.sv
